>>> design/mtm_pkg.sv
// Shared constants and types for the median-of-three / block-mean filter.
`default_nettype none

package mtm_pkg;

    // Widths fixed by the stream and register formats
    localparam int DATA_W       = 16;
    localparam int COUNT_W      = 8;
    localparam int SAMPLE_W_DEF = 16;

    // Average count after reset, and the value a zero write is forced to
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(1);

    // Position of the next sample inside its group of three
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } triple_pos_t;

    // Back end sequencer
    typedef enum logic [1:0] {
        ST_ACC = 2'b01,
        ST_DIV = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

>>> design/mtm_front.sv
// Front end: takes samples, holds each group of three and forms its median.
`default_nettype none

module mtm_front #(
    parameter int SAMPLE_WIDTH = mtm_pkg::SAMPLE_W_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [mtm_pkg::DATA_W-1:0]  s_tdata,
    output logic                             med_valid,
    input  wire logic                        med_ready,
    output logic [SAMPLE_WIDTH-1:0]          med_data
);

    mtm_pkg::triple_pos_t    pos_reg, pos_next;
    logic [SAMPLE_WIDTH-1:0] first_reg, second_reg;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [SAMPLE_WIDTH-1:0] lo, hi;
    logic                    take;

    // Drop sample bits above the converter width
    assign sample = s_tdata[SAMPLE_WIDTH-1:0];

    // Median of the two held samples and the arriving one
    always_comb begin
        lo = (first_reg < second_reg) ? first_reg : second_reg;
        hi = (first_reg < second_reg) ? second_reg : first_reg;
        if (sample > hi) begin
            med_data = hi;
        end else if (sample > lo) begin
            med_data = sample;
        end else begin
            med_data = lo;
        end
    end

    // Third beat of a group needs room in the median queue
    assign med_valid = s_tvalid && (pos_reg == mtm_pkg::POS_THIRD);
    assign s_tready  = (pos_reg != mtm_pkg::POS_THIRD) || med_ready;
    assign take      = s_tvalid && s_tready;

    // Advance the group position
    always_comb begin
        pos_next = pos_reg;
        if (take) begin
            case (pos_reg)
                mtm_pkg::POS_FIRST:  pos_next = mtm_pkg::POS_SECOND;
                mtm_pkg::POS_SECOND: pos_next = mtm_pkg::POS_THIRD;
                default:             pos_next = mtm_pkg::POS_FIRST;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= mtm_pkg::POS_FIRST;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // Hold the first two samples of the group
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= '0;
            second_reg <= '0;
        end else if (take) begin
            if (pos_reg == mtm_pkg::POS_FIRST) begin
                first_reg <= sample;
            end
            if (pos_reg == mtm_pkg::POS_SECOND) begin
                second_reg <= sample;
            end
        end
    end

    // A median leaves only on the beat that completes a group
    a_med_on_third: assert property (@(posedge aclk) disable iff (!aresetn)
        med_valid && med_ready |-> pos_reg == mtm_pkg::POS_THIRD && pos_next == mtm_pkg::POS_FIRST)
        else $error("median pushed outside third beat");

    // The median lies within the three samples
    a_med_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        med_valid |-> med_data >= lo && med_data <= hi || med_data == sample)
        else $error("median out of range");

endmodule

`default_nettype wire

>>> design/mtm_queue.sv
// Two-entry queue of medians between the front and back ends.
`default_nettype none

module mtm_queue #(
    parameter int SAMPLE_WIDTH = mtm_pkg::SAMPLE_W_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [SAMPLE_WIDTH-1:0]      out_data
);

    logic [SAMPLE_WIDTH-1:0] entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store pushed medians
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Fill level tracks the pointer distance
    a_fill_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("fill level and pointers disagree");

    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("queue overfilled");

endmodule

`default_nettype wire

>>> design/mtm_back.sv
// Back end: sums medians per window, divides by the count, holds the result.
`default_nettype none

module mtm_back #(
    parameter int SAMPLE_WIDTH = mtm_pkg::SAMPLE_W_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wen,
    input  wire logic [mtm_pkg::COUNT_W-1:0]  cfg_wdata,
    input  wire logic                         med_valid,
    output logic                              med_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]      med_data,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [mtm_pkg::DATA_W-1:0]        m_tdata
);

    localparam int CW     = mtm_pkg::COUNT_W;
    localparam int SUM_W  = SAMPLE_WIDTH + CW;
    localparam int STEP_W = $clog2(SUM_W + 1);

    mtm_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0]      avg_count_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CW-1:0]      taken_reg, taken_next;
    logic [SUM_W-1:0]   dvd_reg, dvd_next;
    logic [CW-1:0]      dsr_reg, dsr_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    logic [mtm_pkg::DATA_W-1:0] out_data_reg, out_data_next;

    logic [SUM_W-1:0]   sum_plus;
    logic [CW-1:0]      taken_plus;
    logic               pop, close;
    logic [CW:0]        trial, diff;
    logic               qbit;

    // Average count register; a zero write is taken as one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            avg_count_reg <= mtm_pkg::COUNT_RESET;
        end else if (cfg_wen) begin
            avg_count_reg <= (cfg_wdata == '0) ? mtm_pkg::COUNT_MIN : cfg_wdata;
        end
    end

    assign med_ready  = (state_reg == mtm_pkg::ST_ACC);
    assign pop        = med_valid && med_ready;
    assign sum_plus   = sum_reg + SUM_W'(med_data);
    assign taken_plus = taken_reg + CW'(1);
    assign close      = (taken_plus >= avg_count_reg);

    // One restoring divide step per cycle
    assign trial = {rem_reg, dvd_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        taken_next     = taken_reg;
        dvd_next       = dvd_reg;
        dsr_next       = dsr_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            mtm_pkg::ST_ACC: begin
                // Accumulate; close the window into the divider
                if (pop) begin
                    if (close) begin
                        dvd_next   = sum_plus;
                        dsr_next   = taken_plus;
                        rem_next   = '0;
                        step_next  = STEP_W'(SUM_W);
                        sum_next   = '0;
                        taken_next = '0;
                        state_next = mtm_pkg::ST_DIV;
                    end else begin
                        sum_next   = sum_plus;
                        taken_next = taken_plus;
                    end
                end
            end
            mtm_pkg::ST_DIV: begin
                if (step_reg != '0) begin
                    rem_next  = qbit ? diff[CW-1:0] : trial[CW-1:0];
                    dvd_next  = {dvd_reg[SUM_W-2:0], qbit};
                    step_next = step_reg - STEP_W'(1);
                end else if (!out_valid_reg || m_tready) begin
                    // Quotient fits the sample width; hand it to the output
                    out_data_next  = mtm_pkg::DATA_W'(dvd_reg[SAMPLE_WIDTH-1:0]);
                    out_valid_next = 1'b1;
                    state_next     = mtm_pkg::ST_ACC;
                end
            end
            default: begin
                state_next = mtm_pkg::ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mtm_pkg::ST_ACC;
            sum_reg       <= '0;
            taken_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            taken_reg     <= taken_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Divider and output payload
    always_ff @(posedge aclk) begin
        dvd_reg      <= dvd_next;
        dsr_reg      <= dsr_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // No median is taken while a division runs
    a_no_pop_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mtm_pkg::ST_DIV |-> !pop)
        else $error("median taken during divide");

    // Divisor is never zero while dividing
    a_dsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mtm_pkg::ST_DIV |-> dsr_reg != '0)
        else $error("zero divisor");

    // Window count and sum are cleared after each close
    a_taken_below: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(pop) && $past(close) |-> taken_reg == '0 && sum_reg == '0)
        else $error("window not cleared on close");

endmodule

`default_nettype wire

>>> design/median3_then_mean_filter.sv
// Top level of the median-of-three despike filter with block-mean decimation.
//
//   channel   direction  beat contents
//   s_        in         tdata[15:0] raw_sample
//   m_        out        tdata[15:0] filtered_value
//   cfg_      in         wdata[7:0]  average_count (write only)
//
// Every third sample pushes its median into a two-entry queue. The back end
// adds one median per cycle while accumulating, takes none while dividing,
// and at the end of a window runs a one-bit-per-cycle restoring divider on
// the window sum. With small values of average_count the divider limits the
// sample rate; larger counts hide it.
// Reset (aresetn low, synchronous) clears all control state; no clearing pass.
// A stalled result port holds the output register and, once the queue fills,
// back-pressures the sample port.
`default_nettype none

module median3_then_mean_filter #(
    parameter int SAMPLE_WIDTH = mtm_pkg::SAMPLE_W_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wen,
    input  wire logic [mtm_pkg::COUNT_W-1:0]  cfg_wdata,   // [7:0] average_count
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [mtm_pkg::DATA_W-1:0]   s_tdata,     // [15:0] raw_sample
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [mtm_pkg::DATA_W-1:0]        m_tdata      // [15:0] filtered_value
);

    logic                    f_valid, f_ready;
    logic [SAMPLE_WIDTH-1:0] f_data;
    logic                    b_valid, b_ready;
    logic [SAMPLE_WIDTH-1:0] b_data;

    mtm_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .med_valid (f_valid),
        .med_ready (f_ready),
        .med_data  (f_data)
    );

    mtm_queue #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    mtm_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .med_valid (b_valid),
        .med_ready (b_ready),
        .med_data  (b_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> sim/tb_median3_then_mean_filter.sv
// Testbench for the median-of-three despike filter with block-mean decimation.
`timescale 1ns / 1ps

module tb_median3_then_mean_filter;

    localparam int          DATA_W       = mtm_pkg::DATA_W;
    localparam int          COUNT_W      = mtm_pkg::COUNT_W;
    localparam int          CLK_PERIOD   = 10;
    localparam int          DRAIN_CYCLES = 48;      // margin for the divider and the queue
    localparam int          RANDOM_ITEMS = 550;
    localparam logic [15:0] SAMPLE_MAX   = 16'hFFFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata   = '0;       // [15:0] raw_sample
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;              // [15:0] filtered_value

    // Predictor state, mirrors the block's group and window state
    logic [1:0]           grp_pos;
    logic [DATA_W-1:0]    held_a;
    logic [DATA_W-1:0]    held_b;
    logic [COUNT_W-1:0]   win_taken;
    logic [23:0]          win_sum;
    logic [COUNT_W-1:0]   avg_count;

    logic [DATA_W-1:0]    mean_expected[$];
    int unsigned          error_count = 0;
    int unsigned          sink_hold   = 0;
    bit                   src_fast    = 1'b0;
    bit                   sink_fast   = 1'b0;
    logic [DATA_W-1:0]    cluster_base = '0;

    median3_then_mean_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("[%0t] ERROR %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
        error_count++;
    endtask

    // Clear the window state as reset does
    function automatic void reset_filter_state();
        grp_pos   = '0;
        held_a    = '0;
        held_b    = '0;
        win_taken = '0;
        win_sum   = '0;
        avg_count = mtm_pkg::COUNT_RESET;
    endfunction

    // Fold one accepted sample into the window; queue the mean when the window closes
    function automatic void predict_sample(input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] med;
        case (grp_pos)
            2'd0: begin
                held_a  = value;
                grp_pos = 2'd1;
            end
            2'd1: begin
                held_b  = value;
                grp_pos = 2'd2;
            end
            default: begin
                grp_pos = 2'd0;
                lo = (held_a < held_b) ? held_a : held_b;
                hi = (held_a < held_b) ? held_b : held_a;
                if (value > hi)
                    med = hi;
                else if (value > lo)
                    med = value;
                else
                    med = lo;
                win_sum   = win_sum + 24'(med);
                win_taken = win_taken + 1'b1;
                if (win_taken == '0 || win_taken >= avg_count) begin
                    mean_expected.push_back(DATA_W'(win_sum / ((win_taken == '0) ? 1 : win_taken)));
                    win_sum   = '0;
                    win_taken = '0;
                end
            end
        endcase
    endfunction

    // Offer one sample beat after a random gap and wait for it to be taken
    task automatic send_sample(input logic [DATA_W-1:0] value);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_sample(value);
    endtask

    // Drop valid and wait until every expected mean has come out and the back end is quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (mean_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write the average count while the block is idle
    task automatic write_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
        avg_count = (value == '0) ? mtm_pkg::COUNT_MIN : value;
    endtask

    // Mix of extremes, spikes around a level and uniform samples
    function automatic logic [DATA_W-1:0] draw_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return '0;
        if (pick < 24)
            return SAMPLE_MAX;
        if (pick < 55)
            return cluster_base + DATA_W'($urandom_range(0, 64)) - DATA_W'(32);
        return DATA_W'($urandom_range(0, 65535));
    endfunction

    // Every ordering of low, middle and high inside a group, count at its reset value
    task automatic test_median_order();
        logic [DATA_W-1:0] v[3];
        v[0] = '0;
        v[1] = 16'h8000;
        v[2] = SAMPLE_MAX;
        send_sample(v[0]); send_sample(v[1]); send_sample(v[2]);
        send_sample(v[0]); send_sample(v[2]); send_sample(v[1]);
        send_sample(v[1]); send_sample(v[0]); send_sample(v[2]);
        send_sample(v[1]); send_sample(v[2]); send_sample(v[0]);
        send_sample(v[2]); send_sample(v[0]); send_sample(v[1]);
        send_sample(v[2]); send_sample(v[1]); send_sample(v[0]);
    endtask

    // A zero count is held at one; equal pair decides the median
    task automatic test_zero_count();
        write_count('0);
        send_sample(16'h1234);
        send_sample(16'h1234);
        send_sample(16'h0001);
    endtask

    // Lower the count to the medians already summed; window closes at the next median
    task automatic test_count_lowered();
        write_count(8'd3);
        send_sample(16'h0010);
        send_sample(16'h0FFF);
        send_sample(16'h0100);
        write_count(8'd1);
        send_sample(16'hF000);
        send_sample(16'h0003);
        send_sample(16'h7001);
    endtask

    // Widest window at near-full scale so the sum comes near its top
    task automatic test_widest_window();
        write_count(8'd255);
        src_fast = 1'b1;
        repeat (3 * 255) begin
            if ($urandom_range(0, 9) == 0)
                send_sample(DATA_W'($urandom_range(0, 65535)));
            else
                send_sample(SAMPLE_MAX);
        end
        src_fast = 1'b0;
    endtask

    // Random phases: new count, idle pattern and level each phase; partial windows carry over
    task automatic test_random_phases();
        int unsigned  sent;
        int unsigned  beats;
        int unsigned  pick;
        logic [COUNT_W-1:0] count;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                count = 8'd1;
            else if (pick < 40)
                count = 8'd2;
            else if (pick < 85)
                count = COUNT_W'($urandom_range(1, 10));
            else if (pick < 95)
                count = COUNT_W'($urandom_range(11, 40));
            else
                count = '0;
            write_count(count);
            src_fast     = ($urandom_range(0, 3) == 0);
            sink_fast    = ($urandom_range(0, 3) == 0);
            cluster_base = DATA_W'($urandom_range(0, 65535));
            beats = 3 * int'(avg_count) * $urandom_range(1, 4);
            if ($urandom_range(0, 2) == 0)
                beats += $urandom_range(1, 5);
            repeat (beats) send_sample(draw_sample());
            sent += beats;
        end
        sink_fast = 1'b0;
    endtask

    // Check each result beat against the oldest expected mean; draw result-side stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (mean_expected.size() == 0) begin
                report_mismatch("result beat with no mean expected", m_tdata, '0);
            end else begin
                if (m_tdata !== mean_expected[0])
                    report_mismatch("filtered_value", m_tdata, mean_expected[0]);
                void'(mean_expected.pop_front());
            end
            sink_hold = sink_fast ? 0 : $urandom_range(0, 10);
        end
        if (sink_hold != 0) begin
            sink_hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        reset_filter_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_median_order();
        test_zero_count();
        test_count_lowered();
        test_widest_window();
        test_random_phases();

        wait_idle();
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
design/mtm_pkg.sv
design/mtm_front.sv
design/mtm_queue.sv
design/mtm_back.sv
design/median3_then_mean_filter.sv
sim/tb_median3_then_mean_filter.sv
